// ===== hw/rtl/rtfs_pkg.sv =====
package rtfs_pkg;

   // field widths
   localparam int PIXEL_W     = 32;
   localparam int COEF_W      = 32;
   localparam int PROD_W      = 64;
   localparam int SUM_W       = 64;
   localparam int ACC_W       = 66;
   localparam int COL_OUT_W   = 11;
   localparam int ROW_WIDTH_W = 12;
   localparam int ROWS_W      = 11;

   // result word: filtered, column, zero padding
   localparam int RSP_DATA_W = 80;
   localparam int RSP_PAD_W  = RSP_DATA_W - SUM_W - COL_OUT_W;
   localparam int COL_LSB    = SUM_W;

   // csr port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_COEF_LEFT     = 3'd0,
      REG_COEF_CENTER   = 3'd1,
      REG_COEF_RIGHT    = 3'd2,
      REG_ROW_WIDTH     = 3'd3,
      REG_ROWS_PER_PART = 3'd4
   } csr_reg_type;

   // register reset values
   localparam logic [COEF_W-1:0]      COEF_LEFT_RST     = 32'sd0;
   localparam logic [COEF_W-1:0]      COEF_CENTER_RST   = 32'sd1;
   localparam logic [COEF_W-1:0]      COEF_RIGHT_RST    = 32'sd0;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST     = 12'd1280;
   localparam logic [ROWS_W-1:0]      ROWS_PER_PART_RST = 11'd720;

   // saturation limits
   localparam logic [SUM_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;
   localparam logic [SUM_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   // end-of-row and end-of-part marks that travel with a result
   typedef struct packed {
      logic last_in_row;
      logic last_in_part;
   } flags_type;

endpackage

// ===== hw/rtl/row_three_tap_filter_stage.sv =====
// pipeline: a pixel word that is taken moves through the input register, the product register
//   and the result register (rsp) before its result is offered on the filtered stream
// throughput: one pixel word per cycle while the filtered stream does not stall; the last pixel
//   of a row is held until both of its results have gone into the single multiply and sum path
// reset: synchronous, active high; clears pipeline valids, counters and pixel history
//   and loads the register defaults
module row_three_tap_filter_stage #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_ROWS  = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rtfs_pkg::PIXEL_W-1:0]     req_tdata,   // [31:0] pixel
   // filtered stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rtfs_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [63:0] filtered, [74:64] column
   output logic                             rsp_tlast,   // last_in_row
   output logic                             rsp_tuser,   // [0] last_in_part
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rtfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rtfs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rtfs_pkg::*;

   // column counter holds 0 .. MAX_WIDTH-1, effective width up to MAX_WIDTH
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   // row counter holds 0 .. MAX_ROWS-1
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RPW = RW + 1;

   // ---------------- configuration registers ----------------
   logic [COEF_W-1:0]      coef_left_ff, coef_center_ff, coef_right_ff;
   logic [ROW_WIDTH_W-1:0] row_width_ff;
   logic [ROWS_W-1:0]      rows_per_part_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_left_ff     <= COEF_LEFT_RST;
         coef_center_ff   <= COEF_CENTER_RST;
         coef_right_ff    <= COEF_RIGHT_RST;
         row_width_ff     <= ROW_WIDTH_RST;
         rows_per_part_ff <= ROWS_PER_PART_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COEF_LEFT:     coef_left_ff     <= csr_data[COEF_W-1:0];
            REG_COEF_CENTER:   coef_center_ff   <= csr_data[COEF_W-1:0];
            REG_COEF_RIGHT:    coef_right_ff    <= csr_data[COEF_W-1:0];
            REG_ROW_WIDTH:     row_width_ff     <= csr_data[ROW_WIDTH_W-1:0];
            REG_ROWS_PER_PART: rows_per_part_ff <= csr_data[ROWS_W-1:0];
            default: ; // unused indexes are dropped
         endcase
      end
   end

   // clamp width to 2 .. MAX_WIDTH and rows to 1 .. MAX_ROWS
   logic [WW-1:0]  width_eff, last_col;
   logic [RPW-1:0] rows_eff, last_row;

   always_comb begin
      if (32'(row_width_ff) < 32'd2) begin
         width_eff = WW'(2);
      end else if (32'(row_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(row_width_ff);
      end
      if (rows_per_part_ff == '0) begin
         rows_eff = RPW'(1);
      end else if (32'(rows_per_part_ff) > 32'(MAX_ROWS)) begin
         rows_eff = RPW'(MAX_ROWS);
      end else begin
         rows_eff = RPW'(rows_per_part_ff);
      end
      last_col = width_eff - WW'(1);
      last_row = rows_eff - RPW'(1);
   end

   // ---------------- row state ----------------
   logic [PIXEL_W-1:0] prev_ff, prev_in;       // pixel x-1 seen from arriving pixel
   logic [PIXEL_W-1:0] prev2_ff, prev2_in;     // pixel x-2
   logic [CW-1:0]      col_ff, col_in;         // column of the arriving pixel
   logic [RW-1:0]      row_ff, row_in;         // row within the part
   logic               second_ff, second_in;   // first end-of-row result already issued

   logic col_zero, row_end, part_end;

   assign col_zero = (col_ff == '0);
   // width lowered mid-row also lands here, since the compare is at-or-beyond
   assign row_end  = ({1'b0, col_ff} >= last_col);
   assign part_end = ({1'b0, row_ff} >= last_row);

   // ---------------- pipeline enables ----------------
   // input register (a), product register (b), result register (rsp)
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_en, b_en, a_en;

   assign out_en = !rsp_valid_ff || rsp_tready;
   assign b_en   = !b_valid_ff || out_en;
   assign a_en   = !a_valid_ff || b_en;

   // the row's last pixel is held until both of its results have gone in
   assign req_tready = a_en && (!row_end || second_ff);

   logic accept, job_go;
   assign accept = req_tvalid && req_tready;
   // column zero only primes the history and makes no result
   assign job_go = req_tvalid && a_en && !col_zero;

   // ---------------- issue into the input register ----------------
   logic [PIXEL_W-1:0]   a_left_ff, a_center_ff, a_right_ff;
   logic [PIXEL_W-1:0]   a_left_in, a_center_in, a_right_in;
   logic [COL_OUT_W-1:0] a_col_ff, a_col_in;
   flags_type            a_flags_ff, a_flags_in;
   logic [PIXEL_W-1:0]   left_px;

   // left border replicates the edge pixel
   assign left_px = (col_ff == CW'(1)) ? prev_ff : prev2_ff;

   always_comb begin
      a_valid_in  = a_valid_ff;
      a_left_in   = a_left_ff;
      a_center_in = a_center_ff;
      a_right_in  = a_right_ff;
      a_col_in    = a_col_ff;
      a_flags_in  = a_flags_ff;
      second_in   = second_ff;
      if (a_en) begin
         a_valid_in = job_go;
      end
      if (job_go) begin
         if (row_end && second_ff) begin
            // final result of the row, right border replicates the edge pixel
            a_left_in               = prev_ff;
            a_center_in             = req_tdata;
            a_right_in              = req_tdata;
            a_col_in                = COL_OUT_W'(col_ff);
            a_flags_in.last_in_row  = 1'b1;
            a_flags_in.last_in_part = part_end;
            second_in               = 1'b0;
         end else begin
            // result for the previous column
            a_left_in               = left_px;
            a_center_in             = prev_ff;
            a_right_in              = req_tdata;
            a_col_in                = COL_OUT_W'(col_ff - CW'(1));
            a_flags_in.last_in_row  = 1'b0;
            a_flags_in.last_in_part = 1'b0;
            second_in               = row_end;
         end
      end
   end

   // history and counters move only when the pixel word is taken
   always_comb begin
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         prev2_in = prev_ff;
         prev_in  = req_tdata;
         if (col_zero) begin
            col_in = CW'(1);
         end else if (row_end) begin
            col_in = '0;
            row_in = part_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // ---------------- products ----------------
   logic signed [PROD_W-1:0] b_prod_l_ff, b_prod_c_ff, b_prod_r_ff;
   logic signed [PROD_W-1:0] b_prod_l_in, b_prod_c_in, b_prod_r_in;
   logic [COL_OUT_W-1:0]     b_col_ff;
   flags_type                b_flags_ff;

   // three independent 32x32 signed multipliers
   assign b_prod_l_in = $signed(coef_left_ff)   * $signed(a_left_ff);
   assign b_prod_c_in = $signed(coef_center_ff) * $signed(a_center_ff);
   assign b_prod_r_in = $signed(coef_right_ff)  * $signed(a_right_ff);

   always_comb begin
      b_valid_in = b_valid_ff;
      if (b_en) begin
         b_valid_in = a_valid_ff;
      end
   end

   // ---------------- sum and saturate ----------------
   logic signed [ACC_W-1:0] acc;
   logic [SUM_W-1:0]        sat_in, filtered_ff;
   logic [COL_OUT_W-1:0]    column_ff;
   flags_type               rsp_flags_ff;

   // exact sum in 66 bits, then clip to the signed 64-bit range
   assign acc = {{(ACC_W-PROD_W){b_prod_l_ff[PROD_W-1]}}, b_prod_l_ff}
              + {{(ACC_W-PROD_W){b_prod_c_ff[PROD_W-1]}}, b_prod_c_ff}
              + {{(ACC_W-PROD_W){b_prod_r_ff[PROD_W-1]}}, b_prod_r_ff};

   always_comb begin
      if ((acc[ACC_W-1:SUM_W-1] == '0) || (acc[ACC_W-1:SUM_W-1] == '1)) begin
         sat_in = acc[SUM_W-1:0];
      end else if (acc[ACC_W-1]) begin
         sat_in = SAT_MIN;
      end else begin
         sat_in = SAT_MAX;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_en) begin
         rsp_valid_in = b_valid_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
         prev_ff      <= '0;
         prev2_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
         prev_ff      <= prev_in;
         prev2_ff     <= prev2_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      a_left_ff   <= a_left_in;
      a_center_ff <= a_center_in;
      a_right_ff  <= a_right_in;
      a_col_ff    <= a_col_in;
      a_flags_ff  <= a_flags_in;
      if (b_en) begin
         b_prod_l_ff <= b_prod_l_in;
         b_prod_c_ff <= b_prod_c_in;
         b_prod_r_ff <= b_prod_r_in;
         b_col_ff    <= a_col_ff;
         b_flags_ff  <= a_flags_ff;
      end
      if (out_en) begin
         filtered_ff  <= sat_in;
         column_ff    <= b_col_ff;
         rsp_flags_ff <= b_flags_ff;
      end
   end

   // ---------------- result word ----------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, column_ff, filtered_ff};
   assign rsp_tlast  = rsp_flags_ff.last_in_row;
   assign rsp_tuser  = rsp_flags_ff.last_in_part;

endmodule

// ===== hw/rtl/rtfs_checker.sv =====
module rtfs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rtfs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);
   import rtfs_pkg::*;

   // pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // end of part only on the row's final word
   a_part_implies_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("last_in_part without last_in_row");

   // padding bits above the column stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:COL_LSB+COL_OUT_W] == '0)
      else $error("nonzero padding in rsp_tdata");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

endmodule

bind row_three_tap_filter_stage rtfs_checker u_rtfs_checker (.*);

// ===== sim/row_three_tap_filter_stage_test.sv =====
`timescale 1ns / 100ps

module row_three_tap_filter_stage_test;
   import rtfs_pkg::*;

   localparam int FRAME_MAX_WIDTH = 2048;
   localparam int FRAME_MAX_ROWS  = 1024;
   localparam int RESET_CYCLES    = 8;
   localparam int MAX_GAP         = 12;
   // margin after the last expected word has left, before the next phase begins
   localparam int SETTLE_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_ITEMS    = 650;
   localparam int DIRECTED_STEPS  = 38;

   // one expected filtered word
   typedef struct packed {
      logic [SUM_W-1:0]     filtered;
      logic [COL_OUT_W-1:0] column;
      logic                 last_in_row;
      logic                 last_in_part;
   } filter_result_type;

   typedef enum logic {
      STEP_PIXEL,
      STEP_WRITE
   } step_kind_type;

   // directed stimulus row: a pixel word or a register write
   typedef struct packed {
      step_kind_type          kind;
      csr_reg_type            index;
      logic [CSR_DATA_W-1:0]  value;
      logic                   typed;
      logic [SUM_W-1:0]       exp_filtered;
      logic [COL_OUT_W-1:0]   exp_column;
   } directed_step_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PIXEL_W-1:0]      req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   // register image kept by the predictor
   logic [COEF_W-1:0]       wt_left   = COEF_LEFT_RST;
   logic [COEF_W-1:0]       wt_center = COEF_CENTER_RST;
   logic [COEF_W-1:0]       wt_right  = COEF_RIGHT_RST;
   logic [ROW_WIDTH_W-1:0]  line_width = ROW_WIDTH_RST;
   logic [ROWS_W-1:0]       part_rows  = ROWS_PER_PART_RST;

   // pixel history and position of the predictor
   logic [PIXEL_W-1:0]      last_px  = '0;
   logic [PIXEL_W-1:0]      older_px = '0;
   int                      next_col    = 0;
   int                      row_in_part = 0;

   filter_result_type       pending_results [$];
   int                      mismatch_count = 0;
   int                      random_sent = 0;
   bit                      sender_calm   = 1'b0;
   bit                      receiver_calm = 1'b0;

   // directed table: reset defaults, saturation both ways, width and coefficient
   // changes in the middle of a row, clamped widths and part sizes
   directed_step_type directed_steps [DIRECTED_STEPS] = '{
      // defaults after reset: the filter passes the center pixel
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h7FFF_FFFF, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h8000_0000, 1'b1, 64'h0000_0000_7FFF_FFFF, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0000, 1'b1, 64'hFFFF_FFFF_8000_0000, 11'd1},
      // widest row (clamped) and most negative weights, mid-row
      '{STEP_WRITE, REG_ROW_WIDTH,     32'h0000_0FFF, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_COEF_LEFT,     32'h8000_0000, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_COEF_CENTER,   32'h8000_0000, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_COEF_RIGHT,    32'h8000_0000, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h8000_0000, 1'b1, SAT_MAX, 11'd2},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h8000_0000, 1'b1, SAT_MAX, 11'd3},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h8000_0000, 1'b1, SAT_MAX, 11'd4},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h7FFF_FFFF, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h7FFF_FFFF, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h7FFF_FFFF, 1'b1, SAT_MIN, 11'd7},
      // width lowered below the current column: next pixel ends the row
      '{STEP_WRITE, REG_ROW_WIDTH,     32'h0000_0004, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_COEF_LEFT,     32'h0000_0001, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_COEF_CENTER,   32'hFFFF_FFFE, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_COEF_RIGHT,    32'h0000_0003, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0005, 1'b0, 64'h0, 11'd0},
      // zero rows acts as one, width one acts as two
      '{STEP_WRITE, REG_ROWS_PER_PART, 32'h0000_0000, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_ROW_WIDTH,     32'h0000_0001, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'hFFFF_FFFF, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0000, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h7FFF_FFFF, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h8000_0000, 1'b0, 64'h0, 11'd0},
      // two rows per part, three pixels per row
      '{STEP_WRITE, REG_ROW_WIDTH,     32'h0000_0003, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_ROWS_PER_PART, 32'h0000_0002, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_COEF_CENTER,   32'h0000_0001, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0001, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0002, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0003, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0004, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0005, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0006, 1'b0, 64'h0, 11'd0},
      // part size above the limit is clamped
      '{STEP_WRITE, REG_ROWS_PER_PART, 32'h0000_07FF, 1'b0, 64'h0, 11'd0},
      '{STEP_WRITE, REG_COEF_RIGHT,    32'h7FFF_FFFF, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_0001, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h8000_0001, 1'b0, 64'h0, 11'd0},
      '{STEP_PIXEL, REG_COEF_LEFT,     32'h0000_FFFF, 1'b0, 64'h0, 11'd0}
   };

   row_three_tap_filter_stage #(
      .MAX_WIDTH (FRAME_MAX_WIDTH),
      .MAX_ROWS  (FRAME_MAX_ROWS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] pixel
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [63:0] filtered, [74:64] column
      .rsp_tlast  (rsp_tlast),    // last_in_row
      .rsp_tuser  (rsp_tuser),    // [0] last_in_part
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // exact three-tap sum, clipped to the signed 64-bit range
   function automatic logic [SUM_W-1:0] tap_sum(input logic [PIXEL_W-1:0] l,
                                                input logic [PIXEL_W-1:0] c,
                                                input logic [PIXEL_W-1:0] r);
      logic signed [ACC_W-1:0] acc;
      acc = $signed(wt_left) * $signed(l) + $signed(wt_center) * $signed(c)
          + $signed(wt_right) * $signed(r);
      if (acc > $signed({2'b00, SAT_MAX})) begin
         return SAT_MAX;
      end
      if (acc < $signed({2'b11, SAT_MIN})) begin
         return SAT_MIN;
      end
      return acc[SUM_W-1:0];
   endfunction

   // take one pixel word, queue the filtered words it releases
   task automatic advance_filter(input logic [PIXEL_W-1:0] px);
      int             w;
      int             rp;
      logic [PIXEL_W-1:0] left;
      logic           part_done;
      filter_result_type word;
      w  = int'(line_width);
      rp = int'(part_rows);
      if (w < 2) w = 2;
      if (w > FRAME_MAX_WIDTH) w = FRAME_MAX_WIDTH;
      if (rp < 1) rp = 1;
      if (rp > FRAME_MAX_ROWS) rp = FRAME_MAX_ROWS;
      // first pixel of a row only fills the history
      if (next_col == 0) begin
         older_px = last_px;
         last_px  = px;
         next_col = 1;
         return;
      end
      // left edge replicates the first pixel
      left = (next_col == 1) ? last_px : older_px;
      word.filtered     = tap_sum(left, last_px, px);
      word.column       = COL_OUT_W'(next_col - 1);
      word.last_in_row  = 1'b0;
      word.last_in_part = 1'b0;
      pending_results.push_back(word);
      if (next_col >= w - 1) begin
         // end of row: right edge replicates the last pixel
         part_done         = (row_in_part >= rp - 1);
         word.filtered     = tap_sum(last_px, px, px);
         word.column       = COL_OUT_W'(next_col);
         word.last_in_row  = 1'b1;
         word.last_in_part = part_done;
         pending_results.push_back(word);
         next_col    = 0;
         row_in_part = part_done ? 0 : row_in_part + 1;
      end else begin
         next_col = next_col + 1;
      end
      older_px = last_px;
      last_px  = px;
   endtask

   // drive one pixel word after a random gap, predict on acceptance
   task automatic send_pixel(input logic [PIXEL_W-1:0]  px,
                             input logic                typed,
                             input logic [SUM_W-1:0]    exp_filtered,
                             input logic [COL_OUT_W-1:0] exp_column);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      advance_filter(px);
      // rows with a hand-written answer replace the prediction
      if (typed) begin
         pending_results[$] = '{exp_filtered, exp_column, 1'b0, 1'b0};
      end
   endtask

   // one register write; valid stays high for a following write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_COEF_LEFT:     wt_left    = value;
         REG_COEF_CENTER:   wt_center  = value;
         REG_COEF_RIGHT:    wt_right   = value;
         REG_ROW_WIDTH:     line_width = value[ROW_WIDTH_W-1:0];
         REG_ROWS_PER_PART: part_rows  = value[ROWS_W-1:0];
         default: ;
      endcase
   endtask

   // stop sending, wait for every filtered word, then let the pipe empty
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0000_0001;
         5, 6, 7, 8, 9: return $urandom;
         default: return 32'($urandom_range(0, 16)) - 32'd8;
      endcase
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5, 6, 7, 8, 9: return $urandom;
         default: return 32'($urandom_range(0, 200)) - 32'd100;
      endcase
   endfunction

   // mostly short rows; now and then clamped or very wide ones
   function automatic logic [CSR_DATA_W-1:0] pick_width();
      logic [ROW_WIDTH_W-1:0]            w;
      logic [CSR_DATA_W-ROW_WIDTH_W-1:0] junk;
      case ($urandom_range(0, 19))
         0: w = '0;
         1: w = ROW_WIDTH_W'(1);
         2: w = '1;
         3: w = ROW_WIDTH_W'(FRAME_MAX_WIDTH);
         4: w = ROW_WIDTH_W'(FRAME_MAX_WIDTH + 1);
         5, 6, 7: w = ROW_WIDTH_W'($urandom_range(13, 64));
         default: w = ROW_WIDTH_W'($urandom_range(2, 12));
      endcase
      // bits above the register width are dropped
      junk = ($urandom_range(0, 3) == 0) ? (CSR_DATA_W-ROW_WIDTH_W)'($urandom) : '0;
      return {junk, w};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_rows();
      logic [ROWS_W-1:0]            r;
      logic [CSR_DATA_W-ROWS_W-1:0] junk;
      case ($urandom_range(0, 15))
         0: r = '0;
         1: r = '1;
         2: r = ROWS_W'(FRAME_MAX_ROWS);
         3: r = ROWS_W'(FRAME_MAX_ROWS + 1);
         default: r = ROWS_W'($urandom_range(1, 6));
      endcase
      junk = ($urandom_range(0, 3) == 0) ? (CSR_DATA_W-ROWS_W)'($urandom) : '0;
      return {junk, r};
   endfunction

   task automatic report_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // result side: random stalls, compare each word with the oldest prediction
   initial begin : result_sink
      int                stall;
      filter_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected filtered word: expected none actual %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("filtered", want.filtered, rsp_tdata[SUM_W-1:0]);
            report_field("column", SUM_W'(want.column), SUM_W'(rsp_tdata[COL_LSB +: COL_OUT_W]));
            report_field("last_in_row", SUM_W'(want.last_in_row), SUM_W'(rsp_tlast));
            report_field("last_in_part", SUM_W'(want.last_in_part), SUM_W'(rsp_tuser));
         end
      end
   end

   // watchdog: too many cycles without any word moving ends the run
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      bit in_writes;
      int count;
      in_writes = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table; register writes only once the block has gone quiet
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE) begin
            if (!in_writes) begin
               settle_block();
               in_writes = 1'b1;
            end
            write_reg(directed_steps[i].index, directed_steps[i].value);
         end else begin
            if (in_writes) begin
               csr_valid <= 1'b0;
               in_writes = 1'b0;
            end
            send_pixel(directed_steps[i].value, directed_steps[i].typed,
                       directed_steps[i].exp_filtered, directed_steps[i].exp_column);
         end
      end

      // random phases: fresh settings, then a burst of pixel words; rows often
      // stay open across phases so width and weight changes land mid-row
      while (random_sent < RANDOM_ITEMS) begin
         settle_block();
         write_reg(REG_COEF_LEFT, pick_coef());
         write_reg(REG_COEF_CENTER, pick_coef());
         write_reg(REG_COEF_RIGHT, pick_coef());
         write_reg(REG_ROW_WIDTH, pick_width());
         write_reg(REG_ROWS_PER_PART, pick_rows());
         // unused indexes must change nothing
         if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_ROWS_PER_PART + CSR_INDEX_W'($urandom_range(1, 3)), $urandom);
         end
         csr_valid <= 1'b0;
         sender_calm   = ($urandom_range(0, 4) == 0);
         receiver_calm = ($urandom_range(0, 4) == 0);
         count = $urandom_range(10, 50);
         repeat (count) begin
            send_pixel(pick_pixel(), 1'b0, '0, '0);
            random_sent++;
         end
      end

      settle_block();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
